@@ sv/kss_pkg.sv @@
package kss_pkg;

   // Storage geometry
   localparam int unsigned MAX_KNOTS   = 64;
   localparam int unsigned ADDR_W      = $clog2(MAX_KNOTS);
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned CMP_W       = VALUE_W + 2;   // room for value +/- eps
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register fields
   localparam int unsigned DEG_W  = 5;
   localparam int unsigned CNT_W  = 7;
   localparam int unsigned TOL_W  = 16;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned PADDR_W = 4;

   localparam logic [1:0] REG_DEGREE = 2'd0;
   localparam logic [1:0] REG_COUNT  = 2'd1;
   localparam logic [1:0] REG_TOL    = 2'd2;

   localparam logic [DEG_W-1:0] DEGREE_RST = '0;
   localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(2);
   localparam logic [TOL_W-1:0] TOL_RST    = TOL_W'(1);

   // Item codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam int unsigned STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_SHORT = 2'd2
   } kind_type;

   typedef struct packed {
      logic                      action;
      logic [ADDR_W-1:0]         knot_index;
      logic signed [VALUE_W-1:0] knot_value;
      logic signed [VALUE_W-1:0] param_u;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   span_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [DEG_W-1:0] degree;
      logic [CNT_W-1:0] count;
      logic [TOL_W-1:0] tolerance;
   } cfg_type;

   // Classified work handed from front to back. For a write, index is the
   // knot slot; for a query, index is the last domain knot (count - p - 1).
   typedef struct packed {
      kind_type           kind;
      logic [ADDR_W-1:0]  index;
      logic [VALUE_W-1:0] value;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_link_type;

endpackage

@@ sv/kss_front.sv @@
module kss_front
   import kss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   output logic         full,
   input  req_type      req_data,
   output job_link_type job_out,
   input  logic         job_take
);

   job_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   logic [CNT_W-1:0] count_eff;
   logic [CNT_W-1:0] count_min;
   logic [CNT_W-1:0] last_idx;
   job_type          job_new;
   logic             do_push;
   logic             do_pop;

   // classify: clamp count, short-vector test, last domain knot
   always_comb begin
      count_eff = (cfg.count > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : cfg.count;
      count_min = CNT_W'({cfg.degree, 1'b0}) + CNT_W'(2);
      last_idx  = count_eff - CNT_W'(cfg.degree) - CNT_W'(1);
      job_new.index = req_data.knot_index;
      job_new.value = req_data.knot_value;
      if (req_data.action == ACT_WRITE) begin
         job_new.kind = KIND_WRITE;
      end else if (count_eff < count_min) begin
         job_new.kind = KIND_SHORT;
      end else begin
         job_new.kind  = KIND_QUERY;
         job_new.index = last_idx[ADDR_W-1:0];
         job_new.value = req_data.param_u;
      end
   end

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = job_take && (cnt_ff != '0);

   assign job_out.valid = (cnt_ff != '0);
   assign job_out.job   = q_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = do_pop  ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= job_new;
      end
   end

endmodule

@@ sv/kss_back.sv @@
module kss_back
   import kss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  job_link_type job_in,
   output logic         job_take,
   output logic         empty,
   input  logic         pop,
   output rsp_type      rsp_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MIN   = 7'b0000010,
      ST_MAX   = 7'b0000100,
      ST_PROBE = 7'b0001000,
      ST_CMP   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_SPARE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [VALUE_W-1:0] knot_mem_ff [MAX_KNOTS];
   logic [VALUE_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic               wr_en;

   logic signed [VALUE_W-1:0] u_ff, u_in;
   logic signed [VALUE_W-1:0] umin_ff, umin_in;
   logic [ADDR_W-1:0]         last_ff, last_in;
   logic [ADDR_W-1:0]         low_ff, low_in;
   logic [ADDR_W-1:0]         high_ff, high_in;
   rsp_type                   res_ff, res_in;
   logic                      out_vld_ff, out_vld_in;
   rsp_type                   out_ff, out_in;

   logic [ADDR_W:0]          mid_sum;
   logic [ADDR_W-1:0]        mid;
   logic [ADDR_W-1:0]        gap;
   logic signed [CMP_W-1:0]  u_x, umin_x, umax_x, eps_x;
   logic                     lo_out, hi_out, near_hi, near_lo;
   logic                     out_free;

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid     = mid_sum[ADDR_W:1];
   assign gap     = high_ff - low_ff;

   // exact end tests, widened so value +/- eps cannot wrap
   always_comb begin
      u_x    = CMP_W'(u_ff);
      umin_x = CMP_W'(umin_ff);
      umax_x = CMP_W'($signed(rdata_ff));
      eps_x  = $signed({{(CMP_W-TOL_W){1'b0}}, cfg.tolerance});
      lo_out  = u_x < (umin_x - eps_x);
      hi_out  = u_x > (umax_x + eps_x);
      near_hi = !(u_x < (umax_x - eps_x));
      near_lo = !(u_x > (umin_x + eps_x));
   end

   assign out_free = !out_vld_ff || pop;
   assign empty    = !out_vld_ff;
   assign rsp_data = out_ff;
   assign job_take = (state_ff == ST_IDLE) && job_in.valid;
   assign wr_en    = job_take && (job_in.job.kind == KIND_WRITE);

   always_comb begin
      state_in   = state_ff;
      u_in       = u_ff;
      umin_in    = umin_ff;
      last_in    = last_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      res_in     = res_ff;
      out_vld_in = out_vld_ff && !pop;
      out_in     = out_ff;
      rd_en      = 1'b0;
      rd_addr    = ADDR_W'(cfg.degree);
      unique case (state_ff)
         ST_IDLE: begin
            if (job_in.valid) begin
               unique case (job_in.job.kind)
                  KIND_SHORT: begin
                     res_in   = '{span_index: '0, status: STATUS_SHORT};
                     state_in = ST_EMIT;
                  end
                  KIND_QUERY: begin
                     u_in     = $signed(job_in.job.value);
                     last_in  = job_in.job.index;
                     rd_en    = 1'b1;
                     state_in = ST_MIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MIN: begin
            umin_in  = $signed(rdata_ff);
            rd_en    = 1'b1;
            rd_addr  = last_ff;
            state_in = ST_MAX;
         end
         ST_MAX: begin
            state_in = ST_EMIT;
            priority if (lo_out || hi_out) begin
               res_in = '{span_index: '0, status: STATUS_RANGE};
            end else if (near_hi) begin
               res_in = '{span_index: ADDR_W'(last_ff - 1'b1), status: STATUS_OK};
            end else if (near_lo) begin
               res_in = '{span_index: ADDR_W'(cfg.degree), status: STATUS_OK};
            end else begin
               low_in   = ADDR_W'(cfg.degree);
               high_in  = last_ff;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (gap > ADDR_W'(1)) begin
               rd_en    = 1'b1;
               rd_addr  = mid;
               state_in = ST_CMP;
            end else begin
               res_in   = '{span_index: low_ff, status: STATUS_OK};
               state_in = ST_EMIT;
            end
         end
         ST_CMP: begin
            if (u_ff < $signed(rdata_ff)) begin
               high_in = mid;
            end else begin
               low_in = mid;
            end
            state_in = ST_PROBE;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in     = res_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      umin_ff <= umin_in;
      last_ff <= last_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   // knot storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         knot_mem_ff[job_in.job.index] <= job_in.job.value;
      end
      if (rd_en) begin
         rdata_ff <= knot_mem_ff[rd_addr];
      end
   end

endmodule

@@ sv/knot_span_search_core.sv @@
// Knot span lookup for a B-spline knot vector of up to 64 signed Q16.16
// knots. Push beats either store one knot (action 0) or ask for the span
// of parameter u (action 1); only queries produce a result beat on the
// rsp side, in the order the queries were pushed. A two-beat queue sits
// between the front (accept/classify) and the back (knot RAM plus search
// sequencer), so pushes keep landing while the back works or a result
// waits to be popped. Steps in the back per beat: a knot write is stored
// as the beat is taken; a query on a too-short vector goes straight to
// the result hand-off; a query that is out of domain or snaps to an end
// reads the two domain-end knots, then hands off the result; a bisecting
// query adds a knot read and a compare per halving step plus one closing
// probe, the registered RAM read being the pacing item. The knot RAM has
// no reset: a query that reads a knot never written returns an unspecified
// span. Program degree, count and tolerance over the APB port only while
// no query is in flight.

module knot_span_search_core
   import kss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request queue side
   input  logic               push,
   output logic               full,
   input  req_type            req_data,
   // result queue side
   output logic               empty,
   input  logic               pop,
   output rsp_type            rsp_data,
   // APB register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cfg_type      cfg_ff, cfg_in;
   logic         csr_wr;
   logic [1:0]   csr_idx;
   job_link_type job_link;
   logic         job_take;

   // registers at byte offsets 0, 4, 8
   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_DEGREE: cfg_in.degree    = pwdata[DEG_W-1:0];
            REG_COUNT:  cfg_in.count     = pwdata[CNT_W-1:0];
            REG_TOL:    cfg_in.tolerance = pwdata[TOL_W-1:0];
            default:    cfg_in = cfg_ff;   // unmapped offset: write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_DEGREE: prdata = DATA_W'(cfg_ff.degree);
         REG_COUNT:  prdata = DATA_W'(cfg_ff.count);
         REG_TOL:    prdata = DATA_W'(cfg_ff.tolerance);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{degree: DEGREE_RST, count: COUNT_RST, tolerance: TOL_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: takes push beats, classifies them, queues the work
   kss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_out  (job_link),
      .job_take (job_take)
   );

   // back: knot RAM, domain checks, bisection, result register
   kss_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job_in   (job_link),
      .job_take (job_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

@@ sv/kss_checker.sv @@
module kss_checker
   import kss_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input req_type            req_data,
   input logic               empty,
   input logic               pop,
   input rsp_type            rsp_data,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [PADDR_W-1:0] paddr,
   input logic [DATA_W-1:0]  pwdata,
   input logic [DATA_W-1:0]  prdata,
   input logic               pready
);

   // both queues come out of reset with nothing held
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not clear after reset");

   // status code is never the unused encoding
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_RANGE
                  || rsp_data.status == STATUS_SHORT))
      else $error("illegal status on result beat");

   // failed lookups report span zero
   a_err_span_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != STATUS_OK) |-> (rsp_data.span_index == '0))
      else $error("nonzero span with error status");

   // an unpopped result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result beat dropped or changed while stalled");

endmodule

bind knot_span_search_core kss_checker u_kss_checker (.*);

@@ sim/span_check.sv @@
`timescale 1ns / 1ps

module span_check
   import kss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  req_type            req_data,
   input  logic               empty,
   input  logic               pop,
   input  rsp_type            rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]  pwdata,
   input  logic               pready,
   output int                 mismatches,
   output int                 spans_due,
   output int                 knots_written,
   output int                 ok_seen,
   output int                 range_seen,
   output int                 short_seen
);

   localparam int REPORT_LIMIT = 10;

   // Shadow of the knot RAM and the three registers
   logic signed [VALUE_W-1:0] knot_mem [MAX_KNOTS];
   logic [DEG_W-1:0]          cfg_degree = DEGREE_RST;
   logic [CNT_W-1:0]          cfg_count  = COUNT_RST;
   logic [TOL_W-1:0]          cfg_tol    = TOL_RST;

   rsp_type span_due_q [$];

   function automatic rsp_type calc_span(input logic signed [VALUE_W-1:0] u_in);
      rsp_type     res;
      int unsigned deg, cnt, last, lo, hi, mid, span;
      longint      u, eps, umin, umax;
      res = '0;
      deg = cfg_degree;
      cnt = (cfg_count > MAX_KNOTS) ? MAX_KNOTS : cfg_count;
      if (cnt < 2 * deg + 2) begin
         res.status = STATUS_SHORT;
         return res;
      end
      u    = u_in;
      eps  = cfg_tol;
      last = cnt - deg - 1;
      umin = knot_mem[deg];
      umax = knot_mem[last];
      if (u < umin - eps || u > umax + eps) begin
         res.status = STATUS_RANGE;
         return res;
      end
      if (u >= umax - eps) begin
         span = last - 1;
      end else if (u <= umin + eps) begin
         span = deg;
      end else begin
         lo = deg;
         hi = last;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (u < knot_mem[mid]) hi = mid;
            else lo = mid;
         end
         span = lo;
      end
      res.span_index = span[ADDR_W-1:0];
      res.status     = STATUS_OK;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_degree = DEGREE_RST;
         cfg_count  = COUNT_RST;
         cfg_tol    = TOL_RST;
         span_due_q.delete();
      end else begin
         // result side first: a query taken at this edge cannot answer at it
         if (pop && !empty) begin
            if (span_due_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result beat with no query waiting: span %0d status %0d",
                           $time, rsp_data.span_index, rsp_data.status);
            end else begin
               want = span_due_q.pop_front();
               if (rsp_data.span_index !== want.span_index ||
                   rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: span mismatch: expected span %0d status %0d, got span %0d status %0d",
                              $time, want.span_index, want.status,
                              rsp_data.span_index, rsp_data.status);
               end
               case (want.status)
                  STATUS_OK:    ok_seen++;
                  STATUS_RANGE: range_seen++;
                  default:      short_seen++;
               endcase
            end
         end
         if (push && !full) begin
            if (req_data.action == ACT_WRITE) begin
               knot_mem[req_data.knot_index] = req_data.knot_value;
               knots_written++;
            end else begin
               span_due_q.push_back(calc_span(req_data.param_u));
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               {REG_DEGREE, 2'b00}: cfg_degree = pwdata[DEG_W-1:0];
               {REG_COUNT, 2'b00}:  cfg_count  = pwdata[CNT_W-1:0];
               {REG_TOL, 2'b00}:    cfg_tol    = pwdata[TOL_W-1:0];
               default: ;
            endcase
         end
      end
      spans_due = span_due_q.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import kss_pkg::*;

   localparam int     LIMIT_CYCLES    = 400000;
   localparam int     DRAIN_CYCLES    = 64;
   localparam int     HOLD_CYCLES     = 300;
   localparam int     PHASES          = 12;
   localparam int     ITEMS_PER_PHASE = 80;
   localparam longint MAX_VALUE       = 64'sh7FFF_FFFF;
   localparam longint MIN_VALUE       = -MAX_VALUE - 1;
   localparam longint ONE             = 65536;  // 1.0 in Q16.16

   // how a phase lays out its knot vector
   typedef enum logic [1:0] {
      SHAPE_CLAMPED,    // repeated end knots, uniform interior
      SHAPE_RANDOM,     // nondecreasing, random steps, some repeats
      SHAPE_SPREAD,     // from the most negative value up to the top, clipped
      SHAPE_SCRAMBLED   // no order at all
   } shape_type;

   logic               clock   = 1'b0;
   logic               reset   = 1'b1;
   logic               push    = 1'b0;
   req_type            req_data = '0;
   logic               pop     = 1'b0;
   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0]  pwdata  = '0;
   logic               full;
   logic               empty;
   rsp_type            rsp_data;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   int mismatches, spans_due, knots_written, ok_seen, range_seen, short_seen;

   // stimulus-side view of the knots and registers (shapes queries only)
   longint      knot_plan [MAX_KNOTS];
   int unsigned cur_deg, cur_cnt, cur_tol;
   int unsigned send_idle_pct, recv_idle_pct;
   int          settings_done;
   int          cycle_count;
   logic        hold_active = 1'b0;
   event        hold_off_go;

   knot_span_search_core dut (
      .clock, .reset,
      .push, .full, .req_data,
      .empty, .pop, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   span_check span_check_i (
      .clock, .reset,
      .push, .full, .req_data,
      .empty, .pop, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatches, .spans_due, .knots_written, .ok_seen, .range_seen, .short_seen
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Long result stall, counted here so the sender keeps pushing meanwhile
   always begin
      @(hold_off_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_active = 1'b0;
   end

   // Result side: pop drops at random, or for the whole hold-off
   always @(negedge clock) begin
      if (hold_active || $urandom_range(0, 99) < recv_idle_pct) pop <= 1'b0;
      else pop <= 1'b1;
   end

   // One push beat. Starts and ends on a falling edge; push stays high after
   // the beat so back-to-back beats never toggle it within one step.
   task automatic push_beat(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      if (item.action == ACT_WRITE) knot_plan[item.knot_index] = item.knot_value;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_knot(input int unsigned idx, input longint value);
      req_type item;
      item            = '0;
      item.action     = ACT_WRITE;
      item.knot_index = idx[ADDR_W-1:0];
      item.knot_value = value[VALUE_W-1:0];
      item.param_u    = $urandom;   // don't-care on a write
      push_beat(item);
   endtask

   task automatic push_query(input longint u);
      req_type item;
      item            = '0;
      item.action     = ACT_QUERY;
      item.knot_index = ADDR_W'($urandom);   // don't-care on a query
      item.knot_value = $urandom;
      item.param_u    = u[VALUE_W-1:0];
      push_beat(item);
   endtask

   // Stop pushing, wait until every span has come back, then let trailing
   // knot writes (which never answer) clear the back end.
   task automatic settle();
      push <= 1'b0;
      while (spans_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB write: setup, access, wait for pready. Junk above the field width
   // checks that the register keeps only its own bits.
   task automatic csr_write(input logic [1:0] reg_idx, input int unsigned value,
                            input int unsigned width);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= ($urandom << width) | value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input int unsigned deg, input int unsigned cnt,
                             input int unsigned tol);
      settle();
      csr_write(REG_DEGREE, deg, DEG_W);
      csr_write(REG_COUNT, cnt, CNT_W);
      csr_write(REG_TOL, tol, TOL_W);
      cur_deg = deg;
      cur_cnt = cnt;
      cur_tol = tol;
      settings_done++;
   endtask

   // Rewrite all 64 slots so no query ever reads a slot left unwritten.
   task automatic load_knots(input shape_type shape);
      longint      v, step, knot_val;
      int unsigned cnt, inner, k;
      cnt   = (cur_cnt > MAX_KNOTS) ? MAX_KNOTS : cur_cnt;
      inner = (cnt > 2 * cur_deg + 1) ? cnt - 2 * cur_deg - 1 : 1;
      step  = $urandom_range(1, 1 << 18);
      if (shape == SHAPE_SPREAD) v = MIN_VALUE + longint'($urandom_range(0, 3));
      else v = -longint'($urandom_range(0, 1 << 22));
      for (int i = 0; i < MAX_KNOTS; i++) begin
         case (shape)
            SHAPE_CLAMPED: begin
               k = (i < cur_deg) ? 0 : i - cur_deg;
               if (k > inner) k = inner;
               knot_val = v + longint'(k) * step;
            end
            SHAPE_RANDOM: begin
               if ($urandom_range(0, 4) != 0) v = v + longint'($urandom_range(1, 1 << 18));
               knot_val = v;
            end
            SHAPE_SPREAD: begin
               if (i > 0) v = v + longint'($urandom_range(0, 1 << 27));
               if (v > MAX_VALUE) v = MAX_VALUE;
               knot_val = v;
            end
            default: knot_val = int'($urandom);
         endcase
         push_knot(i, knot_val);
      end
   endtask

   // Query parameter: mostly inside the domain, on knots, or around the
   // domain ends at +/- tolerance; the rest anywhere in the 32-bit range.
   function automatic longint pick_param();
      int unsigned cnt, last, j, roll;
      longint      lo, hi, u, eps, base;
      cnt  = (cur_cnt > MAX_KNOTS) ? MAX_KNOTS : cur_cnt;
      eps  = cur_tol;
      roll = $urandom_range(0, 99);
      if (cnt < 2 * cur_deg + 2 || roll >= 88) begin
         if (roll >= 88 && roll < 91) u = MIN_VALUE;
         else if (roll >= 91 && roll < 94) u = MAX_VALUE;
         else u = int'($urandom);
      end else begin
         last = cnt - cur_deg - 1;
         if (roll < 45) begin
            j  = $urandom_range(cur_deg, last - 1);
            lo = knot_plan[j];
            hi = knot_plan[j + 1];
            u  = (hi > lo) ? lo + longint'($urandom % (hi - lo + 1)) : lo;
         end else if (roll < 60) begin
            u = knot_plan[$urandom_range(cur_deg, last)] + longint'($urandom_range(0, 2)) - 1;
         end else begin
            base = ($urandom_range(0, 1) == 0) ? knot_plan[cur_deg] : knot_plan[last];
            u = base + eps * (longint'($urandom_range(0, 2)) - 1)
                + longint'($urandom_range(0, 2)) - 1;
         end
      end
      if (u > MAX_VALUE) u = MAX_VALUE;
      else if (u < MIN_VALUE) u = MIN_VALUE;
      return u;
   endfunction

   function automatic void phase_plan(input int ph, output int unsigned deg,
                                      output int unsigned cnt, output int unsigned tol,
                                      output shape_type shape);
      case (ph)
         0:  begin deg = 3;  cnt = 12;  tol = 1;     shape = SHAPE_CLAMPED;   end
         1:  begin deg = 0;  cnt = 2;   tol = 0;     shape = SHAPE_RANDOM;    end
         2:  begin deg = 31; cnt = 64;  tol = 65535; shape = SHAPE_SPREAD;    end
         3:  begin deg = 2;  cnt = 127; tol = 300;   shape = SHAPE_RANDOM;    end
         4:  begin deg = 5;  cnt = 20;  tol = 0;     shape = SHAPE_CLAMPED;   end
         5:  begin deg = 1;  cnt = 64;  tol = 65535; shape = SHAPE_SCRAMBLED; end
         6:  begin deg = 0;  cnt = 64;  tol = 16;    shape = SHAPE_RANDOM;    end
         7:  begin deg = 10; cnt = 0;   tol = 100;   shape = SHAPE_SPREAD;    end
         8:  begin deg = 4;  cnt = 65;  tol = 2;     shape = SHAPE_CLAMPED;   end
         9:  begin deg = 15; cnt = 33;  tol = 1;     shape = SHAPE_RANDOM;    end
         10: begin deg = 7;  cnt = 40;  tol = 1000;  shape = SHAPE_SCRAMBLED; end
         default: begin deg = 2; cnt = 9; tol = 65535; shape = SHAPE_RANDOM;  end
      endcase
   endfunction

   initial begin
      int unsigned roll, j, deg, cnt, tol;
      longint      lo, hi;
      shape_type   shape;
      cur_deg       = DEGREE_RST;
      cur_cnt       = COUNT_RST;
      cur_tol       = TOL_RST;
      send_idle_pct = 0;
      recv_idle_pct = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Whole knot RAM written once, under the reset registers (p=0, 2 knots)
      load_knots(SHAPE_CLAMPED);

      // Directed: domain covering the full value range -> every u snaps to span 0
      push_knot(0, MIN_VALUE);
      push_knot(1, MAX_VALUE);
      push_query(MIN_VALUE);
      push_query(MAX_VALUE);
      push_query(0);
      // narrow domain, tolerance 1: just outside, just inside, middle at each end
      push_knot(0, -ONE);
      push_knot(1, ONE);
      push_query(-ONE - 2);
      push_query(-ONE - 1);
      push_query(0);
      push_query(ONE + 1);
      push_query(ONE + 2);
      // p=1 over six knots with repeated ends, exact compares, real bisection
      set_config(1, 6, 0);
      push_knot(0, -2 * ONE);
      push_knot(1, -2 * ONE);
      push_knot(2, -ONE);
      push_knot(3, ONE);
      push_knot(4, 2 * ONE);
      push_knot(5, 2 * ONE);
      push_query(-2 * ONE);
      push_query(-ONE);
      push_query(0);
      push_query(ONE);
      push_query(2 * ONE - 1);
      // too-short vectors: a single knot, and one knot short of 2p+2
      set_config(1, 1, 0);
      push_query(0);
      set_config(10, 21, 5);
      push_query(0);

      // Random phases: sender slow / receiver slower, then swapped, then no idling
      for (int ph = 0; ph < PHASES; ph++) begin
         phase_plan(ph, deg, cnt, tol, shape);
         set_config(deg, cnt, tol);
         send_idle_pct = (ph < 4) ? 25 : (ph < 8) ? 85 : 0;
         recv_idle_pct = (ph < 4) ? 85 : (ph < 8) ? 25 : 0;
         load_knots(shape);
         // receiver freezes while pushes continue -> queue fills, full asserts
         if (ph == 4 || ph == 9) -> hold_off_go;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               // rewrite a knot between its neighbors, keeping the order
               j  = $urandom_range(0, MAX_KNOTS - 1);
               lo = (j > 0) ? knot_plan[j - 1] : knot_plan[j];
               hi = (j < MAX_KNOTS - 1) ? knot_plan[j + 1] : knot_plan[j];
               push_knot(j, (hi > lo) ? lo + longint'($urandom % (hi - lo + 1)) : lo);
            end else if (roll < 14) begin
               // noise: any value anywhere, may break the order
               push_knot($urandom_range(0, MAX_KNOTS - 1), int'($urandom));
            end else begin
               push_query(pick_param());
            end
         end
      end

      settle();
      $display("Coverage: %0d knot writes, %0d span lookups (%0d in span, %0d outside, %0d short)",
               knots_written, ok_seen + range_seen + short_seen, ok_seen, range_seen, short_seen);
      $display("Swept %0d register settings under three idling mixes with two long result stalls",
               settings_done);
      if (mismatches == 0 && spans_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
